>>> rtl/positional_pair_list_macros.svh
// assertion macros for the positional pair list checker
// every macro samples on clk and reports through $error
`ifndef POSITIONAL_PAIR_LIST_MACROS_SVH
`define POSITIONAL_PAIR_LIST_MACROS_SVH

// checked only while out of reset
`define PLP_ASSERT_RUN(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PLP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/plp_pkg.sv
// shared constants, codes and control structs of the positional pair list
// no dependencies
package plp_pkg;

	localparam int DEPTH   = 32;
	localparam int DATA_W  = 32;
	localparam int OP_W    = 3;
	localparam int POS_W   = 6;
	localparam int ST_W    = 2;
	localparam int COUNT_W = 6;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
	localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;
	localparam logic [OP_W-1:0] OP_DUMP       = 3'd6;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

	typedef struct packed {
		logic exec;
		logic dump_start;
		logic dump_step;
	} cmd_t;

	typedef struct packed {
		logic is_dump;
		logic empty;
		logic dump_last;
	} sts_t;

endpackage

>>> rtl/plp_ctrl.sv
// controller of the positional pair list: request handshake, dump sequencing
// and result valid; depends on plp_pkg
module plp_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	output logic        res_valid,
	input  logic        res_stall,
	input  plp_pkg::sts_t sts,
	output plp_pkg::cmd_t cmd
);
	import plp_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic state_q;
	logic res_valid_q;
	logic slot_free;
	logic accept;
	logic dump_go;

	assign slot_free = !res_valid_q || !res_stall;
	assign req_stall = !((state_q == S_IDLE) && slot_free);
	assign accept    = req_valid && !req_stall;
	assign dump_go   = sts.is_dump && !sts.empty;

	assign cmd.exec       = accept && !dump_go;
	assign cmd.dump_start = accept && dump_go;
	assign cmd.dump_step  = (state_q == S_DUMP) && slot_free;

	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				res_valid_q <= cmd.exec || cmd.dump_step;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.dump_start) begin
						state_q <= S_DUMP;
					end
				end
				S_DUMP: begin
					if (cmd.dump_step && sts.dump_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/plp_datapath.sv
// datapath of the positional pair list: cell chain of pairs, fill count,
// dump index and result registers; depends on plp_pkg
module plp_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  plp_pkg::cmd_t                     cmd,
	output plp_pkg::sts_t                     sts,
	input  logic [plp_pkg::OP_W-1:0]          op,
	input  logic signed [plp_pkg::DATA_W-1:0] first_value,
	input  logic signed [plp_pkg::DATA_W-1:0] second_value,
	input  logic [plp_pkg::POS_W-1:0]         position,
	output logic [plp_pkg::ST_W-1:0]          status,
	output logic [plp_pkg::COUNT_W-1:0]       count,
	output logic signed [plp_pkg::DATA_W-1:0] out_first,
	output logic signed [plp_pkg::DATA_W-1:0] out_second,
	output logic                              last
);
	import plp_pkg::*;

	logic signed [DATA_W-1:0] first_q  [DEPTH];
	logic signed [DATA_W-1:0] second_q [DEPTH];
	logic signed [DATA_W-1:0] left_f   [DEPTH];
	logic signed [DATA_W-1:0] left_s   [DEPTH];
	logic signed [DATA_W-1:0] right_f  [DEPTH];
	logic signed [DATA_W-1:0] right_s  [DEPTH];

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic [IDX_W-1:0]   dump_idx_q;
	logic [CMP_W-1:0]   cnt_ext;
	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   idx_wide;
	logic [IDX_W-1:0]   idx;
	logic [ST_W-1:0]    st;
	logic               do_ins;
	logic               do_del;
	logic               full;
	logic               empty;

	logic [ST_W-1:0]          status_q;
	logic [COUNT_W-1:0]       count_out_q;
	logic signed [DATA_W-1:0] out_first_q;
	logic signed [DATA_W-1:0] out_second_q;
	logic                     last_q;

	assign cnt_ext = CMP_W'(count_q);
	assign pos_ext = CMP_W'(position);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);

	// operation decode and range checks
	always_comb begin
		st       = ST_OK;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		idx_wide = '0;
		case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					do_ins   = 1'b1;
					idx_wide = cnt_ext;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					do_del = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					do_del   = 1'b1;
					idx_wide = cnt_ext - CMP_W'(1);
				end
			end
			OP_INSERT: begin
				if (full) begin
					st = ST_FULL;
				end else if (pos_ext > cnt_ext + CMP_W'(1)) begin
					st = ST_BADPOS;
				end else begin
					do_ins = 1'b1;
					if (pos_ext != '0) begin
						idx_wide = pos_ext - CMP_W'(1);
					end
				end
			end
			OP_DELETE: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
					st = ST_BADPOS;
				end else begin
					do_del   = 1'b1;
					idx_wide = pos_ext - CMP_W'(1);
				end
			end
			OP_DUMP: begin
				if (empty) begin
					st = ST_EMPTY;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign idx = IDX_W'(idx_wide);

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_del) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign sts.is_dump   = (op == OP_DUMP);
	assign sts.empty     = empty;
	assign sts.dump_last = (CNT_W'(dump_idx_q) + CNT_W'(1) == count_q);

	// cell chain: from the index on, each cell loads from its left neighbor on
	// insert (the indexed cell takes the new pair) and from its right on delete
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam logic [IDX_W-1:0] G_IDX = IDX_W'(g);

		if (g == 0) begin : g_head
			assign left_f[g] = first_value;
			assign left_s[g] = second_value;
		end else begin : g_body
			assign left_f[g] = first_q[g-1];
			assign left_s[g] = second_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign right_f[g] = first_q[g];
			assign right_s[g] = second_q[g];
		end else begin : g_inner
			assign right_f[g] = first_q[g+1];
			assign right_s[g] = second_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec && G_IDX >= idx) begin
				if (do_ins) begin
					first_q[g]  <= (G_IDX == idx) ? first_value  : left_f[g];
					second_q[g] <= (G_IDX == idx) ? second_value : left_s[g];
				end else if (do_del) begin
					first_q[g]  <= right_f[g];
					second_q[g] <= right_s[g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dump_idx_q <= '0;
		end else begin
			if (cmd.exec) begin
				count_q <= count_next;
			end
			if (cmd.dump_start) begin
				dump_idx_q <= '0;
			end else if (cmd.dump_step) begin
				dump_idx_q <= IDX_W'(dump_idx_q + IDX_W'(1));
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q     <= st;
			count_out_q  <= COUNT_W'(count_next);
			out_first_q  <= '0;
			out_second_q <= '0;
			last_q       <= 1'b1;
		end else if (cmd.dump_step) begin
			status_q     <= ST_OK;
			count_out_q  <= COUNT_W'(count_q);
			out_first_q  <= first_q[dump_idx_q];
			out_second_q <= second_q[dump_idx_q];
			last_q       <= sts.dump_last;
		end
	end

	assign status     = status_q;
	assign count      = count_out_q;
	assign out_first  = out_first_q;
	assign out_second = out_second_q;
	assign last       = last_q;

endmodule

>>> rtl/positional_pair_list.sv
// An ordered list of up to 32 pairs of signed 32-bit values with push and pop at
// either end, insert and delete at a 1-based position, and a dump of the whole
// list. Every request except dump answers with one result (status and count) in
// the next cycle, so such requests can follow one per cycle while results are
// taken; insert and delete shift the cell chain as the result is registered. A
// dump of n pairs streams n results, one per cycle while results are taken, the
// final one marked by last, and no request is taken until the final pair has
// gone into the result register. The list storage needs no clearing after reset.
// top level: joins plp_ctrl and plp_datapath; depends on plp_pkg
module positional_pair_list (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [plp_pkg::OP_W-1:0]          op,
	input  logic signed [plp_pkg::DATA_W-1:0] first_value,
	input  logic signed [plp_pkg::DATA_W-1:0] second_value,
	input  logic [plp_pkg::POS_W-1:0]         position,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [plp_pkg::ST_W-1:0]          status,
	output logic [plp_pkg::COUNT_W-1:0]       count,
	output logic signed [plp_pkg::DATA_W-1:0] out_first,
	output logic signed [plp_pkg::DATA_W-1:0] out_second,
	output logic                              last
);
	import plp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	plp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	plp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.first_value  (first_value),
		.second_value (second_value),
		.position     (position),
		.status       (status),
		.count        (count),
		.out_first    (out_first),
		.out_second   (out_second),
		.last         (last)
	);

endmodule

>>> rtl/plp_checker.sv
// port-level checker of the positional pair list and its bind to the top level
// depends on plp_pkg and positional_pair_list_macros.svh
`include "positional_pair_list_macros.svh"

module plp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_stall,
	input logic [plp_pkg::OP_W-1:0]          op,
	input logic signed [plp_pkg::DATA_W-1:0] first_value,
	input logic signed [plp_pkg::DATA_W-1:0] second_value,
	input logic [plp_pkg::POS_W-1:0]         position,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic [plp_pkg::ST_W-1:0]          status,
	input logic [plp_pkg::COUNT_W-1:0]       count,
	input logic signed [plp_pkg::DATA_W-1:0] out_first,
	input logic signed [plp_pkg::DATA_W-1:0] out_second,
	input logic                              last
);
	import plp_pkg::*;

	// only a dumped pair carries data
	`PLP_ASSERT_ALWAYS(a_zero_data, res_valid && status != ST_OK |-> out_first == '0 && out_second == '0, "non-ok result with data")

	// an empty report means an empty list and ends the request
	`PLP_ASSERT_ALWAYS(a_empty_count, res_valid && status == ST_EMPTY |-> count == '0 && last, "empty status with pairs held")

	// only a dump gives more than one result
	`PLP_ASSERT_ALWAYS(a_multi_ok, res_valid && !last |-> status == ST_OK, "non-final result not ok")

	// full is only reported at capacity
	`PLP_ASSERT_ALWAYS(a_full_count, res_valid && status == ST_FULL |-> count == COUNT_W'(DEPTH), "full status below capacity")

	// a stalled result holds
	`PLP_ASSERT_RUN(a_res_hold, res_valid && res_stall |=> res_valid && $stable(status) && $stable(count) && $stable(out_first) && $stable(out_second) && $stable(last), "stalled result changed")

endmodule

bind positional_pair_list plp_checker u_plp_checker (.*);
